// ===== rtl/lbfs_pkg.sv =====
// Package: shared constants, codes and types of the linked block file store.
`timescale 1ns / 1ps
package lbfs_pkg;

  // Table geometry
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 8;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int DATA_W      = BLOCK_BYTES * 8;
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int STORE_W     = FILL_W + DATA_W;

  // Free-map search groups of eight blocks
  localparam int GROUPS      = (NUM_BLOCKS + 7) / 8;
  localparam int GSEL_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Port field widths
  localparam int OP_W        = 2;
  localparam int BYTES_W     = 64;
  localparam int LEN_W       = 4;
  localparam int SIZE_W      = 10;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_CHUNK = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_READ,
    ST_RESP
  } state_e;

  // Commands into the free map
  typedef struct packed {
    logic             set_en;
    logic [BLK_W-1:0] set_idx;
    logic             clr_en;
    logic [BLK_W-1:0] clr_idx;
  } fmap_cmd_t;

  // Registered search result of the free map
  typedef struct packed {
    logic             any_free;
    logic [BLK_W-1:0] idx;
  } fmap_stat_t;

endpackage

// ===== rtl/lbfs_in_if.sv =====
// Interface: input channel carrying one command transaction.
`timescale 1ns / 1ps
interface lbfs_in_if
  import lbfs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic               overwrite;
  logic [BYTES_W-1:0] chunk_bytes;
  logic [LEN_W-1:0]   chunk_length;

  modport source (
    output valid, operation, overwrite, chunk_bytes, chunk_length,
    input  ready
  );

  modport sink (
    input  valid, operation, overwrite, chunk_bytes, chunk_length,
    output ready
  );
endinterface

// ===== rtl/lbfs_out_if.sv =====
// Interface: output channel carrying one result transaction.
`timescale 1ns / 1ps
interface lbfs_out_if
  import lbfs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               status;
  logic [BYTES_W-1:0] read_bytes;
  logic [LEN_W-1:0]   read_length;
  logic               last;
  logic [SIZE_W-1:0]  file_size;

  modport source (
    output valid, status, read_bytes, read_length, last, file_size,
    input  ready
  );

  modport sink (
    input  valid, status, read_bytes, read_length, last, file_size,
    output ready
  );
endinterface

// ===== rtl/lbfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lbfs_free_map.sv =====
// Free map: one used bit per block and a registered lowest-free-block search.
`timescale 1ns / 1ps
module lbfs_free_map
  import lbfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fmap_cmd_t  cmd_i,
  output fmap_stat_t stat_o
);

  logic [NUM_BLOCKS-1:0] used_q;
  logic [NUM_BLOCKS-1:0] used_d;
  logic [GROUPS*8-1:0]   pad;
  logic [GROUPS-1:0]     grp_free;
  logic [GSEL_W-1:0]     gsel;
  logic [7:0]            grp_bits;
  logic [2:0]            bsel;
  fmap_stat_t            stat_q;
  fmap_stat_t            stat_d;

  // Used-bit updates
  always_comb begin
    used_d = used_q;
    if (cmd_i.set_en) begin
      used_d[cmd_i.set_idx] = 1'b1;
    end
    if (cmd_i.clr_en) begin
      used_d[cmd_i.clr_idx] = 1'b0;
    end
  end

  // Two-level search: first group with a free block, then first block in it
  always_comb begin
    pad                  = '1;
    pad[NUM_BLOCKS-1:0]  = used_q;
    gsel                 = '0;
    bsel                 = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_free[g] = ~&pad[g*8 +: 8];
    end
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        gsel = GSEL_W'(g);
      end
    end
    grp_bits = pad[gsel*8 +: 8];
    for (int b = 7; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bsel = 3'(b);
      end
    end
    stat_d.any_free = |grp_free;
    stat_d.idx      = BLK_W'({gsel, bsel});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      stat_q <= '0;
    end else begin
      used_q <= used_d;
      stat_q <= stat_d;
    end
  end

  assign stat_o = stat_q;

endmodule

// ===== rtl/linked_block_file_store.sv =====
// Top level: linked block file store, chain walker and result register.
// Flow: an accepted command goes to a work state that loads the output register; an
//   overwrite start frees its chain first. Only idle accepts, so commands never overlap;
//   the link read sets the walk to a block a cycle, a read walk only while out is free.
// Reset: used bits, head, tail, size and failure flag clear at once, no clearing pass;
//   block contents and links are undefined until written.
`timescale 1ns / 1ps
module linked_block_file_store
  import lbfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  lbfs_in_if.sink           in_i,
  lbfs_out_if.source        out_o
);

  state_e state_q, state_d;

  // File state
  logic [BLK_W-1:0]  head_q, head_d;
  logic [BLK_W-1:0]  tail_q, tail_d;
  logic              empty_q, empty_d;
  logic [SIZE_W-1:0] total_q, total_d;
  logic              failed_q, failed_d;

  // Walk and pending chunk
  logic [BLK_W-1:0]  cur_q, cur_d;
  logic              resp_status_q, resp_status_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [FILL_W-1:0] len_q, len_d;

  // Output register
  logic              out_valid_q;
  logic              out_status_q;
  logic [BYTES_W-1:0] out_bytes_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_last_q;
  logic [SIZE_W-1:0] out_size_q;

  logic              out_load;
  logic              ld_status;
  logic [BYTES_W-1:0] ld_bytes;
  logic [LEN_W-1:0]  ld_len;
  logic              ld_last;
  logic [SIZE_W-1:0] ld_size;

  logic              in_fire;
  logic              slot_free;
  logic [FILL_W-1:0] len_sat;
  logic [DATA_W-1:0] data_masked;
  logic [SIZE_W-1:0] total_inc;

  // Memory ports
  logic              rd_re;
  logic [BLK_W-1:0]  rd_addr;
  logic              st_we;
  logic [STORE_W-1:0] st_wdata;
  logic [STORE_W-1:0] st_rdata;
  logic              lk_we;
  logic [BLK_W-1:0]  lk_rdata;

  fmap_cmd_t         fmap_cmd;
  fmap_stat_t        fmap_stat;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign total_inc  = total_q + SIZE_W'(len_q);

  // Saturate chunk length and drop bytes beyond it
  always_comb begin
    if (in_i.chunk_length > LEN_W'(BLOCK_BYTES)) begin
      len_sat = FILL_W'(BLOCK_BYTES);
    end else begin
      len_sat = FILL_W'(in_i.chunk_length);
    end
    for (int b = 0; b < BLOCK_BYTES; b++) begin
      if (b < int'(len_sat)) begin
        data_masked[b*8 +: 8] = in_i.chunk_bytes[b*8 +: 8];
      end else begin
        data_masked[b*8 +: 8] = 8'h00;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(in_i.operation))
            OP_START: state_d = (in_i.overwrite && !empty_q) ? ST_FREE : ST_RESP;
            OP_CHUNK: begin
              state_d = (failed_q || in_i.chunk_length == '0) ? ST_RESP : ST_ALLOC;
            end
            OP_READ:  state_d = empty_q ? ST_RESP : ST_READ;
            OP_NONE:  state_d = ST_RESP;
          endcase
        end
      end
      ST_ALLOC: if (slot_free) state_d = ST_IDLE;
      ST_FREE:  if (cur_q == tail_q) state_d = ST_RESP;
      ST_READ:  if (slot_free && cur_q == tail_q) state_d = ST_IDLE;
      ST_RESP:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    empty_d       = empty_q;
    total_d       = total_q;
    failed_d      = failed_q;
    cur_d         = cur_q;
    resp_status_d = resp_status_q;
    data_d        = data_q;
    len_d         = len_q;
    rd_re         = 1'b0;
    rd_addr       = head_q;
    st_we         = 1'b0;
    st_wdata      = {len_q, data_q};
    lk_we         = 1'b0;
    fmap_cmd      = '0;
    fmap_cmd.set_idx = fmap_stat.idx;
    fmap_cmd.clr_idx = cur_q;
    out_load      = 1'b0;
    ld_status     = 1'b0;
    ld_bytes      = '0;
    ld_len        = '0;
    ld_last       = 1'b1;
    ld_size       = total_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          data_d        = data_masked;
          len_d         = len_sat;
          resp_status_d = 1'b0;
          cur_d         = head_q;
          unique case (op_e'(in_i.operation))
            OP_START: begin
              failed_d = 1'b0;
              rd_re    = in_i.overwrite && !empty_q;
            end
            OP_CHUNK: resp_status_d = failed_q;
            OP_READ:  rd_re = !empty_q;
            OP_NONE:  resp_status_d = 1'b0;
          endcase
        end
      end
      // Take the lowest free block, store the chunk, link it after the tail, or fail if none
      ST_ALLOC: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (fmap_stat.any_free) begin
            st_we           = 1'b1;
            lk_we           = !empty_q;
            fmap_cmd.set_en = 1'b1;
            if (empty_q) begin
              head_d = fmap_stat.idx;
            end
            tail_d  = fmap_stat.idx;
            empty_d = 1'b0;
            total_d = total_inc;
            ld_size = total_inc;
          end else begin
            failed_d  = 1'b1;
            ld_status = 1'b1;
          end
        end
      end
      // Release one chain block per cycle
      ST_FREE: begin
        fmap_cmd.clr_en = 1'b1;
        if (cur_q == tail_q) begin
          empty_d = 1'b1;
          total_d = '0;
        end else begin
          cur_d   = lk_rdata;
          rd_re   = 1'b1;
          rd_addr = lk_rdata;
        end
      end
      // Emit one chain block per cycle while the output slot is free
      ST_READ: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_bytes = BYTES_W'(st_rdata[DATA_W-1:0]);
          ld_len   = LEN_W'(st_rdata[STORE_W-1:DATA_W]);
          ld_last  = (cur_q == tail_q);
          if (cur_q != tail_q) begin
            cur_d   = lk_rdata;
            rd_re   = 1'b1;
            rd_addr = lk_rdata;
          end
        end
      end
      ST_RESP: begin
        out_load  = slot_free;
        ld_status = resp_status_q;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      total_q     <= '0;
      failed_q    <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      total_q  <= total_d;
      failed_q <= failed_d;
      cur_q    <= cur_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    resp_status_q <= resp_status_d;
    data_q        <= data_d;
    len_q         <= len_d;
    if (out_load) begin
      out_status_q <= ld_status;
      out_bytes_q  <= ld_bytes;
      out_len_q    <= ld_len;
      out_last_q   <= ld_last;
      out_size_q   <= ld_size;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.read_bytes  = out_bytes_q;
  assign out_o.read_length = out_len_q;
  assign out_o.last        = out_last_q;
  assign out_o.file_size   = out_size_q;

  // Block contents with fill count
  lbfs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (NUM_BLOCKS)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (fmap_stat.idx),
    .wdata_i (st_wdata),
    .re_i    (rd_re),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  // Next-block links, written when a block gains a successor
  lbfs_ram #(
    .WIDTH (BLK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (tail_q),
    .wdata_i (fmap_stat.idx),
    .re_i    (rd_re),
    .raddr_i (rd_addr),
    .rdata_o (lk_rdata)
  );

  lbfs_free_map u_free_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (fmap_cmd),
    .stat_o (fmap_stat)
  );

`ifndef SYNTHESIS
  // An empty file has no bytes
  a_empty_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> total_q == '0)
    else $error("empty file with nonzero size");

  // Allocation is only attempted while no failure is pending
  a_alloc_not_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ALLOC |-> !failed_q)
    else $error("allocation with failure flag set");

  // Releasing the tail block empties the file
  a_free_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FREE && cur_q == tail_q) |=> empty_q && state_q == ST_RESP)
    else $error("free walk did not empty the file");

  // Every accepted transaction moves the machine out of idle in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted transaction left no work");
`endif

endmodule
